// File: hw/rtl/flbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// flbm_pkg
// Field widths, command and error codes of the fixed latency byte memory.
// -----------------------------------------------------------------------------
package flbm_pkg;

    localparam int CMD_W  = 2;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 2;
    localparam int DATA_W = 32;
    localparam int ERR_W  = 2;
    localparam int LAT_W  = 8;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BUSY  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_COUNT = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

    localparam logic [CNT_W-1:0] MAX_BYTES_PER_REQUEST = 2'd2;
    localparam logic [LAT_W-1:0] LATENCY_RESET         = 8'd1;

endpackage
`default_nettype wire

// File: hw/rtl/flbm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// flbm_req_if / flbm_rsp_if
// Valid/ready channels for memory commands and their results.
// -----------------------------------------------------------------------------
interface flbm_req_if
    import flbm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  byte_count;
    logic [DATA_W-1:0] write_value;

    modport source (output valid, command, address, byte_count, write_value, input ready);
    modport sink   (input valid, command, address, byte_count, write_value, output ready);
endinterface

interface flbm_rsp_if
    import flbm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              ready_res;
    logic [DATA_W-1:0] read_data;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, ready_res, read_data, error_code, input ready);
    modport sink   (input valid, ready_res, read_data, error_code, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/flbm_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// flbm_bank
// Single-port byte-wide synchronous RAM, one access per cycle, registered read.
// -----------------------------------------------------------------------------
module flbm_bank #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hw/rtl/fixed_latency_byte_memory_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// fixed_latency_byte_memory_core
// Little-endian byte memory with one outstanding request and a set latency.
// -----------------------------------------------------------------------------
// Usage:
//   req carries commands (tick, read, write) with address, byte count and
//   write value; rsp returns exactly one transaction per command: completion
//   flag, data and error code, in command order.
//   cfg_write_en / cfg_write_data set the latency in ticks (a zero setting acts as the smallest nonzero one).
// Throughput: one command per cycle while rsp is not stalled; a tick that
//   completes an in-range read then waits in ST_RDATA for the registered bank read.
// Result: presented the cycle after its command is taken; for a completing
//   read, it follows the ST_RDATA state, after the registered bank read.
// Reset: the store is split into an even and an odd byte bank of
//   (MEM_BYTES+1)/2 rows; after reset both are zeroed one row per cycle
//   with req.ready low. Config writes still apply.
// Stall: the result sits in an output register; while rsp is stalled and
//   the register is full, req.ready is low.
// -----------------------------------------------------------------------------
module fixed_latency_byte_memory_core
    import flbm_pkg::*;
#(
    parameter int MEM_BYTES = 131072
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    flbm_req_if.sink              req,
    flbm_rsp_if.source            rsp,
    input  wire logic             cfg_write_en,
    input  wire logic [LAT_W-1:0] cfg_write_data
);

    localparam int ROWS = (MEM_BYTES + 1) / 2;
    localparam int RW   = $clog2(ROWS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_RDATA = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [RW-1:0]     clr_row_reg, clr_row_next;
    logic [LAT_W-1:0]  latency_reg;

    logic              pending_reg, pending_next;
    logic              pend_read_reg, pend_read_next;
    logic [LAT_W-1:0]  cycles_reg, cycles_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]  pend_count_reg, pend_count_next;
    logic [DATA_W-1:0] pend_data_reg, pend_data_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_rdy_reg, out_rdy_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [ERR_W-1:0]  out_err_reg, out_err_next;

    logic              in_fire;
    logic              is_request;
    logic [LAT_W-1:0]  cycles_dec;
    logic [ADDR_W:0]   end_addr;
    logic              out_of_range;
    logic              addr_odd;
    logic [RW-1:0]     half_row;
    logic              b0_en, b1_en;
    logic [7:0]        byte0, byte1;
    logic [DATA_W-1:0] rd_value;

    logic              even_we, odd_we;
    logic [RW-1:0]     even_addr, odd_addr;
    logic [7:0]        even_wdata, odd_wdata;
    logic [7:0]        even_rdata, odd_rdata;

    flbm_bank #(.DEPTH(ROWS), .AW(RW)) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .addr  (even_addr),
        .wdata (even_wdata),
        .rdata (even_rdata)
    );

    flbm_bank #(.DEPTH(ROWS), .AW(RW)) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .addr  (odd_addr),
        .wdata (odd_wdata),
        .rdata (odd_rdata)
    );

    assign req.ready      = (state_reg == ST_RUN) && (!out_valid_reg || rsp.ready);
    assign in_fire        = req.valid && req.ready;
    assign is_request     = (req.command == CMD_READ) || (req.command == CMD_WRITE);
    assign cycles_dec     = (cycles_reg == '0) ? '0 : cycles_reg - LAT_W'(1);
    assign end_addr       = {1'b0, pend_addr_reg} + (ADDR_W + 1)'(pend_count_reg);
    assign out_of_range   = end_addr > (ADDR_W + 1)'(MEM_BYTES);

    // Byte 0 sits in the odd bank when the address is odd; byte 1 then moves
    // to the next even row.
    assign addr_odd       = pend_addr_reg[0];
    assign half_row       = pend_addr_reg[RW:1];
    assign b0_en          = pend_count_reg != '0;
    assign b1_en          = pend_count_reg == CNT_W'(2);

    assign byte0    = addr_odd ? odd_rdata : even_rdata;
    assign byte1    = addr_odd ? even_rdata : odd_rdata;
    assign rd_value = b1_en ? {16'd0, byte1, byte0} :
                      b0_en ? {24'd0, byte0} : '0;

    always_comb
    begin
        state_next      = state_reg;
        clr_row_next    = clr_row_reg;
        pending_next    = pending_reg;
        pend_read_next  = pend_read_reg;
        cycles_next     = cycles_reg;
        pend_addr_next  = pend_addr_reg;
        pend_count_next = pend_count_reg;
        pend_data_next  = pend_data_reg;
        out_valid_next  = out_valid_reg;
        out_rdy_next    = out_rdy_reg;
        out_data_next   = out_data_reg;
        out_err_next    = out_err_reg;

        even_addr  = (addr_odd && b1_en) ? half_row + RW'(1) : half_row;
        odd_addr   = half_row;
        even_we    = 1'b0;
        odd_we     = 1'b0;
        even_wdata = addr_odd ? pend_data_reg[15:8] : pend_data_reg[7:0];
        odd_wdata  = addr_odd ? pend_data_reg[7:0] : pend_data_reg[15:8];

        // Drop the held result once the receiver takes it.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                even_addr  = clr_row_reg;
                odd_addr   = clr_row_reg;
                even_we    = 1'b1;
                odd_we     = 1'b1;
                even_wdata = '0;
                odd_wdata  = '0;
                clr_row_next = clr_row_reg + RW'(1);
                if (clr_row_reg == RW'(ROWS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RDATA:
            begin
                out_valid_next = 1'b1;
                out_rdy_next   = 1'b1;
                out_data_next  = rd_value;
                out_err_next   = ERR_NONE;
                state_next     = ST_RUN;
            end
            ST_RUN:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    out_rdy_next   = 1'b0;
                    out_data_next  = '0;
                    out_err_next   = ERR_NONE;
                    if (is_request)
                    begin
                        if (pending_reg)
                        begin
                            out_err_next = ERR_BUSY;
                        end
                        else if (req.byte_count > MAX_BYTES_PER_REQUEST)
                        begin
                            out_err_next = ERR_COUNT;
                        end
                        else
                        begin
                            pending_next    = 1'b1;
                            pend_read_next  = req.command == CMD_READ;
                            cycles_next     = latency_reg;
                            pend_addr_next  = req.address;
                            pend_count_next = req.byte_count;
                            pend_data_next  = (req.command == CMD_READ) ? '0 : req.write_value;
                        end
                    end
                    else if ((req.command == CMD_TICK) && pending_reg)
                    begin
                        cycles_next = cycles_dec;
                        if (cycles_dec == '0)
                        begin
                            pending_next = 1'b0;
                            out_rdy_next = 1'b1;
                            if (out_of_range)
                            begin
                                out_err_next = ERR_RANGE;
                            end
                            else if (pend_read_reg)
                            begin
                                // Hold the result until the banks return data.
                                out_valid_next = 1'b0;
                                state_next     = ST_RDATA;
                            end
                            else
                            begin
                                even_we       = addr_odd ? b1_en : b0_en;
                                odd_we        = addr_odd ? b0_en : b1_en;
                                out_data_next = pend_data_reg;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_row_reg    <= '0;
            latency_reg    <= LATENCY_RESET;
            pending_reg    <= 1'b0;
            pend_read_reg  <= 1'b0;
            cycles_reg     <= '0;
            pend_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            pending_reg    <= pending_next;
            pend_read_reg  <= pend_read_next;
            cycles_reg     <= cycles_next;
            pend_count_reg <= pend_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write_en)
            begin
                latency_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        out_rdy_reg   <= out_rdy_next;
        out_data_reg  <= out_data_next;
        out_err_reg   <= out_err_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ready_res  = out_rdy_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.error_code = out_err_reg;

endmodule
`default_nettype wire

// File: dv/fixed_latency_byte_memory_core_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fixed_latency_byte_memory_core_test
// Self-checking bench for the fixed latency byte memory. Commands go in on the
// req channel and are mirrored by a byte-level model of the store and the one
// outstanding request. Every rsp transaction is compared field by field with
// the oldest predicted reply. Directed corner cases come first, then phases of
// random request/tick sequences under several latencies and stall profiles.
// -----------------------------------------------------------------------------
module fixed_latency_byte_memory_core_test;

    import flbm_pkg::*;

    localparam int MEM_BYTES = 131072;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0] CNT_OVER   = 2'd3;

    typedef struct packed {
        logic              ready_res;
        logic [DATA_W-1:0] read_data;
        logic [ERR_W-1:0]  error_code;
    } mem_reply_t;

    class memory_mirror;
        byte unsigned      store [MEM_BYTES];
        bit                busy;
        bit                busy_read;
        bit [LAT_W-1:0]    ticks_left;
        bit [ADDR_W-1:0]   req_addr;
        bit [CNT_W-1:0]    req_cnt;
        bit [DATA_W-1:0]   req_data;
        bit [LAT_W-1:0]    latency = LATENCY_RESET;
        mem_reply_t        predicted_replies [$];
        int                mismatches;

        function void note_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                   logic [CNT_W-1:0] cnt, logic [DATA_W-1:0] wval);
            mem_reply_t        r;
            bit [DATA_W-1:0]   v;
            longint unsigned   last;
            r = '{1'b0, '0, ERR_NONE};
            if (cmd == CMD_READ || cmd == CMD_WRITE)
            begin
                if (busy)
                    r.error_code = ERR_BUSY;
                else if (cnt > MAX_BYTES_PER_REQUEST)
                    r.error_code = ERR_COUNT;
                else
                begin
                    busy       = 1'b1;
                    busy_read  = (cmd == CMD_READ);
                    ticks_left = latency;
                    req_addr   = addr;
                    req_cnt    = cnt;
                    req_data   = busy_read ? '0 : wval;
                end
            end
            else if (cmd == CMD_TICK && busy)
            begin
                // a latency of zero still takes one tick
                if (ticks_left > 0)
                    ticks_left = ticks_left - 1'b1;
                if (ticks_left == 0)
                begin
                    busy = 1'b0;
                    r.ready_res = 1'b1;
                    last = longint'(req_addr) + longint'(req_cnt);
                    if (last > longint'(MEM_BYTES))
                        r.error_code = ERR_RANGE;
                    else
                    begin
                        if (busy_read)
                        begin
                            v = '0;
                            for (int i = 0; i < req_cnt; i++)
                                v[8*i +: 8] = store[req_addr + i];
                            req_data = v;
                        end
                        else
                        begin
                            for (int i = 0; i < req_cnt; i++)
                                store[req_addr + i] = req_data[8*i +: 8];
                        end
                        r.read_data = req_data;
                    end
                end
            end
            predicted_replies.push_back(r);
        endfunction

        function void check_reply(logic rdy, logic [DATA_W-1:0] data, logic [ERR_W-1:0] err);
            mem_reply_t exp_r;
            if (predicted_replies.size() == 0)
            begin
                $error("unexpected reply: ready_res %0d read_data 0x%08h error_code %0d",
                       rdy, data, err);
                mismatches++;
                return;
            end
            exp_r = predicted_replies.pop_front();
            if (rdy !== exp_r.ready_res)
            begin
                $error("ready_res: expected %0d, actual %0d", exp_r.ready_res, rdy);
                mismatches++;
            end
            if (data !== exp_r.read_data)
            begin
                $error("read_data: expected 0x%08h, actual 0x%08h", exp_r.read_data, data);
                mismatches++;
            end
            if (err !== exp_r.error_code)
            begin
                $error("error_code: expected %0d, actual %0d", exp_r.error_code, err);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_write_en;
    logic [LAT_W-1:0] cfg_write_data;
    int               src_idle_pct;
    int               snk_idle_pct;

    memory_mirror mirror = new();

    flbm_req_if req_bus ();
    flbm_rsp_if rsp_bus ();

    fixed_latency_byte_memory_core #(
        .MEM_BYTES (MEM_BYTES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_bus),
        .rsp            (rsp_bus),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
                mirror.check_reply(rsp_bus.ready_res, rsp_bus.read_data, rsp_bus.error_code);
        end
    end

    function automatic logic [ADDR_W-1:0] pick_address();
        int sel;
        sel = $urandom_range(99);
        // favor a small window so reads hit earlier writes
        if (sel < 55)
            return $urandom_range(63);
        else if (sel < 70)
            return MEM_BYTES - 4 + $urandom_range(6);
        else if (sel < 90)
            return $urandom_range(MEM_BYTES - 1);
        else
            return $urandom();
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                input logic [CNT_W-1:0] cnt, input logic [DATA_W-1:0] wval);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.command     <= cmd;
        req_bus.address     <= addr;
        req_bus.byte_count  <= cnt;
        req_bus.write_value <= wval;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        mirror.note_command(cmd, addr, cnt, wval);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_command(CMD_TICK, $urandom(), CNT_W'($urandom_range(3)), $urandom());
    endtask

    task automatic stop_and_drain();
        req_bus.valid <= 1'b0;
        while (mirror.predicted_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_latency(input logic [LAT_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        mirror.latency = value;
    endtask

    task automatic run_random(input int count);
        int issued;
        int pick;
        issued = 0;
        while (issued < count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // well-formed request, then mostly ticks, with stray requests and unused commands, until it completes
                send_command($urandom_range(1) ? CMD_READ : CMD_WRITE, pick_address(),
                             CNT_W'($urandom_range(2)), $urandom());
                issued++;
                while (mirror.busy)
                begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                        send_command($urandom_range(1) ? CMD_READ : CMD_WRITE, pick_address(),
                                     CNT_W'($urandom_range(3)), $urandom());
                    else if (pick < 11)
                        send_command(CMD_UNUSED, $urandom(), CNT_W'($urandom_range(3)),
                                     $urandom());
                    else
                        send_tick();
                    issued++;
                end
            end
            else if (pick < 85)
            begin
                send_command(CMD_W'($urandom_range(3)), pick_address(),
                             CNT_W'($urandom_range(3)), $urandom());
                issued++;
            end
            else
            begin
                send_command($urandom_range(1) ? CMD_READ : CMD_WRITE, pick_address(),
                             CNT_OVER, $urandom());
                issued++;
            end
        end
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct,
                             input logic [LAT_W-1:0] lat, input int count);
        stop_and_drain();
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_latency(lat);
        run_random(count);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = '0;
        req_bus.valid       = 1'b0;
        req_bus.command     = CMD_TICK;
        req_bus.address     = '0;
        req_bus.byte_count  = '0;
        req_bus.write_value = '0;
        src_idle_pct        = 29;
        snk_idle_pct        = 46;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners at the reset latency
        send_tick();
        send_command(CMD_UNUSED, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        send_command(CMD_WRITE, 32'd0, 2'd2, 32'hA5C3_1234);
        send_command(CMD_READ, 32'd0, 2'd1, 32'd0);
        send_command(CMD_WRITE, 32'd4, CNT_OVER, 32'd0);
        send_tick();
        send_command(CMD_READ, 32'd0, 2'd2, 32'd0);
        send_tick();
        send_command(CMD_READ, 32'd1, 2'd1, 32'd0);
        send_tick();
        send_command(CMD_READ, 32'd0, 2'd0, 32'd0);
        send_tick();
        send_command(CMD_WRITE, 32'd0, 2'd0, 32'hFFFF_FFFF);
        send_tick();
        send_command(CMD_READ, 32'd0, CNT_OVER, 32'd0);
        send_command(CMD_WRITE, MEM_BYTES - 2, 2'd2, 32'h0000_FFFF);
        send_tick();
        send_command(CMD_READ, MEM_BYTES - 2, 2'd2, 32'd0);
        send_tick();
        send_command(CMD_READ, MEM_BYTES - 1, 2'd2, 32'd0);
        send_tick();
        send_command(CMD_WRITE, 32'hFFFF_FFFF, 2'd1, 32'h5A5A_5A5A);
        send_tick();
        send_command(CMD_READ, MEM_BYTES, 2'd0, 32'd0);
        send_tick();

        run_phase(29, 46, 8'd3, 300);
        run_phase(29, 46, 8'd0, 250);
        run_phase(46, 29, 8'd1, 300);
        run_phase(46, 29, 8'd255, 400);
        run_phase(0, 0, LAT_W'($urandom_range(20, 2)), 350);
        run_phase(0, 0, 8'd8, 250);

        stop_and_drain();
        repeat (10) @(negedge clk);
        if (mirror.mismatches == 0 && mirror.predicted_replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
